[sv/dpf_pkg.sv]
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared types, constants and helpers of the detection proposal filter.
// ----------------------------------------------------------------------------
`default_nettype none

package dpf_pkg;

    localparam int VALUE_W      = 32;
    localparam int SCORE_W      = 31;
    localparam int CLASS_W      = 7;
    localparam int THRESH_W     = 17;
    localparam int COUNT_W      = 8;
    localparam int POS_W        = 8;
    localparam int BOX_VALUES   = 4;
    localparam int MAX_CLASSES  = 128;

    localparam int RESULT_BITS  = 4 * VALUE_W + SCORE_W + CLASS_W;
    localparam int RESULT_W     = ((RESULT_BITS + 7) / 8) * 8;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(32768);
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(80);
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = COUNT_W'(MAX_CLASSES);

    // register indexes, taken from paddr[2]
    localparam logic REG_THRESHOLD   = 1'b0;
    localparam logic REG_CLASS_COUNT = 1'b1;

    typedef struct packed {
        logic [CLASS_W-1:0]        class_index;
        logic [SCORE_W-1:0]        best_score;
        logic signed [VALUE_W-1:0] bottom_y;
        logic signed [VALUE_W-1:0] right_x;
        logic signed [VALUE_W-1:0] top_y;
        logic signed [VALUE_W-1:0] left_x;
    } result_t;

    typedef struct packed {
        logic [THRESH_W-1:0] score_threshold;
        logic [COUNT_W-1:0]  class_count;
    } cfg_t;

    // clamp a 33-bit signed sum to the 32-bit signed range
    function automatic logic [VALUE_W-1:0] sat32(input logic signed [VALUE_W:0] v);
        logic [VALUE_W-1:0] r;
        if (v[VALUE_W] != v[VALUE_W-1]) begin
            r = v[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
            r = v[VALUE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/dpf_core.sv]
// ----------------------------------------------------------------------------
// dpf_core
// Per-proposal tracking: stores the box, keeps the best class score and forms
// the thresholded corner result on the last element of a proposal.
// ----------------------------------------------------------------------------
`default_nettype none

module dpf_core import dpf_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire cfg_t                       cfg,
    input  wire logic                       in_accept,
    input  wire logic signed [VALUE_W-1:0]  in_value,
    output logic                            emit,
    output result_t                         result
);

    logic [POS_W-1:0]          pos_reg,   pos_next;
    logic signed [VALUE_W-1:0] box_reg [BOX_VALUES];
    logic signed [VALUE_W-1:0] score_reg, score_next;
    logic [CLASS_W-1:0]        class_reg, class_next;
    logic                      seen_reg,  seen_next;

    logic [COUNT_W-1:0]        count_eff;
    logic [POS_W-1:0]          last_pos;
    logic                      in_box;
    logic                      at_end;
    logic                      better;
    logic signed [VALUE_W-1:0] half_w, half_h;

    always_comb begin
        count_eff  = (cfg.class_count > COUNT_MAX) ? COUNT_MAX : cfg.class_count;
        last_pos   = POS_W'(count_eff) + POS_W'(3);
        in_box     = (pos_reg < POS_W'(BOX_VALUES));
        at_end     = (pos_reg >= last_pos);
        better     = !in_box && (in_value > score_reg);

        score_next = better ? in_value : score_reg;
        class_next = better ? CLASS_W'(pos_reg - POS_W'(BOX_VALUES)) : class_reg;
        seen_next  = seen_reg || better;
        pos_next   = at_end ? '0 : pos_reg + POS_W'(1);

        emit = in_accept && at_end && seen_next &&
               ($signed({score_next[VALUE_W-1], score_next}) >
                $signed({{(VALUE_W+1-THRESH_W){1'b0}}, cfg.score_threshold}));

        // box values are all stored before any class can be seen
        half_w = box_reg[2] >>> 1;
        half_h = box_reg[3] >>> 1;
        result.left_x      = sat32({box_reg[0][VALUE_W-1], box_reg[0]} -
                                   {half_w[VALUE_W-1], half_w});
        result.top_y       = sat32({box_reg[1][VALUE_W-1], box_reg[1]} -
                                   {half_h[VALUE_W-1], half_h});
        result.right_x     = sat32({box_reg[0][VALUE_W-1], box_reg[0]} +
                                   {half_w[VALUE_W-1], half_w});
        result.bottom_y    = sat32({box_reg[1][VALUE_W-1], box_reg[1]} +
                                   {half_h[VALUE_W-1], half_h});
        result.best_score  = score_next[SCORE_W-1:0];
        result.class_index = class_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            score_reg <= '0;
            class_reg <= '0;
            seen_reg  <= 1'b0;
            for (int i = 0; i < BOX_VALUES; i++) begin
                box_reg[i] <= '0;
            end
        end else if (in_accept) begin
            if (in_box) begin
                box_reg[pos_reg[1:0]] <= in_value;
            end
            pos_reg <= pos_next;
            // clear tracking at the end of a proposal
            if (at_end) begin
                score_reg <= '0;
                class_reg <= '0;
                seen_reg  <= 1'b0;
            end else begin
                score_reg <= score_next;
                class_reg <= class_next;
                seen_reg  <= seen_next;
            end
        end
    end

endmodule

`default_nettype wire

[sv/detection_proposal_filter_top.sv]
// Output: the result of a proposal is registered into the output stage, or into
// the skid entry while that stage stalls, when its last element is accepted.
// Throughput: one input value per cycle in a single registered pass, unless both
// output entries are full; a two-entry output stage keeps input flowing while a result waits.
// Reset: aresetn (synchronous, active low) clears tracking, box values, the
// output stage, and restores the threshold to 0.5 and the class count to 80.
// ----------------------------------------------------------------------------
// detection_proposal_filter_top
// Decodes a stream of detection proposals into thresholded boxes, with an
// APB-style register port.
// ----------------------------------------------------------------------------
`default_nettype none

module detection_proposal_filter_top import dpf_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [VALUE_W-1:0]   s_tdata,   // [31:0] value
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [RESULT_W-1:0]       m_tdata    // [31:0] left_x, [63:32] top_y,
                                                 // [95:64] right_x, [127:96] bottom_y,
                                                 // [158:128] best_score,
                                                 // [165:159] class_index, zero pad
);

    cfg_t    cfg_reg;
    logic    wr_en;
    logic    in_accept;
    logic    emit;
    result_t result;

    result_t out_reg;
    logic    out_valid_reg;
    result_t skid_reg;
    logic    skid_valid_reg;
    logic    out_free;

    // register port
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.score_threshold <= THRESH_RESET;
            cfg_reg.class_count     <= COUNT_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_THRESHOLD:   cfg_reg.score_threshold <= pwdata[THRESH_W-1:0];
                REG_CLASS_COUNT: cfg_reg.class_count     <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_THRESHOLD:   prdata = {{(32-THRESH_W){1'b0}}, cfg_reg.score_threshold};
            REG_CLASS_COUNT: prdata = {{(32-COUNT_W){1'b0}}, cfg_reg.class_count};
            default:         prdata = '0;
        endcase
    end

    // input side stalls only when both output entries are full
    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;

    dpf_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_accept (in_accept),
        .in_value  (s_tdata),
        .emit      (emit),
        .result    (result)
    );

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= emit;
            end
        end else if (emit) begin
            // hold the new result behind the stalled one
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end else if (emit) begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(RESULT_W-RESULT_BITS){1'b0}}, out_reg};

endmodule

`default_nettype wire
